// ===== rtl/bls_pkg.sv =====
// Package for the bounded LIFO stack: operation and status codes, reset constants,
// and the packed beat and control types shared by the stack modules.
// No dependencies.
`timescale 1ns / 1ps

package bls_pkg;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_PEEK   = 3'd2;
    localparam logic [2:0] OP_TOP    = 3'd3;
    localparam logic [2:0] OP_BOTTOM = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_INVALID   = 2'd3;

    localparam logic signed [31:0] ERR_VALUE = -32'sd1;
    localparam logic [4:0]         CAP_RESET = 5'd16;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] push_value;
        logic [4:0]         depth_from_top;
    } t_in;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic               is_empty;
        logic               is_full;
    } t_out;

    // Memory strobes from the controller to the entry store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    // Result of one operation, waiting for the memory read data.
    typedef struct packed {
        logic       valid;
        logic       use_data;
        logic [1:0] status;
        logic       is_empty;
        logic       is_full;
    } t_res_info;

endpackage

// ===== rtl/bls_mem.sv =====
// Entry store of the bounded LIFO stack: one synchronous single-port memory
// with a registered read. Depends on bls_pkg.
`timescale 1ns / 1ps

module bls_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic               i_clk,
    input  bls_pkg::t_mem_ctl  i_ctl,
    input  logic [AW-1:0]      i_addr,
    input  logic signed [31:0] i_wr_data,
    output logic signed [31:0] o_rd_data
);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
    end

    // The read data holds until the next read, so a stalled result keeps it.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/bls_ctrl.sv =====
// Controller of the bounded LIFO stack: holds the entry count, decodes each operation
// into at most one memory access and keeps the pending result. Depends on bls_pkg.
`timescale 1ns / 1ps

module bls_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  bls_pkg::t_in          i_in_data,
    input  logic [4:0]            i_capacity,
    input  logic                  i_take,
    output bls_pkg::t_mem_ctl     o_mem_ctl,
    output logic [AW-1:0]         o_mem_addr,
    output bls_pkg::t_res_info    o_res
);

    localparam int CMPW = (CW > 5) ? CW : 5;
    localparam logic [CMPW-1:0] DEPTH_X = CMPW'(DEPTH);

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    bls_pkg::t_res_info  r_res;
    logic                accept;
    logic                wr;
    logic                rd;
    logic [1:0]          st;
    logic [AW-1:0]       addr;
    logic [CMPW-1:0]     cnt_x;
    logic [CMPW-1:0]     cap_x;
    logic [CMPW-1:0]     pos_x;
    logic [CMPW-1:0]     peek_idx;
    logic [CMPW-1:0]     ncnt_x;
    logic                full_now;

    assign o_in_ready = !r_res.valid || i_take;
    assign accept     = i_in_valid && o_in_ready;

    assign cnt_x    = CMPW'(r_count);
    assign cap_x    = CMPW'(i_capacity);
    assign pos_x    = CMPW'(i_in_data.depth_from_top);
    assign peek_idx = cnt_x - pos_x;
    assign full_now = (cnt_x >= cap_x) || (cnt_x >= DEPTH_X);
    assign ncnt_x   = CMPW'(n_count);

    always_comb begin
        n_count = r_count;
        wr      = 1'b0;
        rd      = 1'b0;
        st      = bls_pkg::ST_OK;
        addr    = '0;
        case (i_in_data.operation)
            bls_pkg::OP_PUSH: begin
                if (full_now) begin
                    st = bls_pkg::ST_OVERFLOW;
                end else begin
                    wr      = 1'b1;
                    addr    = r_count[AW-1:0];
                    n_count = r_count + 1'b1;
                end
            end
            bls_pkg::OP_POP: begin
                if (r_count == '0) begin
                    st = bls_pkg::ST_UNDERFLOW;
                end else begin
                    rd      = 1'b1;
                    n_count = r_count - 1'b1;
                    addr    = n_count[AW-1:0];
                end
            end
            bls_pkg::OP_PEEK: begin
                if (pos_x == '0 || pos_x > cnt_x) begin
                    st = bls_pkg::ST_INVALID;
                end else begin
                    rd   = 1'b1;
                    addr = peek_idx[AW-1:0];
                end
            end
            bls_pkg::OP_TOP: begin
                if (r_count == '0) begin
                    st = bls_pkg::ST_UNDERFLOW;
                end else begin
                    rd   = 1'b1;
                    addr = AW'(r_count - 1'b1);
                end
            end
            bls_pkg::OP_BOTTOM: begin
                if (r_count == '0) begin
                    st = bls_pkg::ST_UNDERFLOW;
                end else begin
                    rd = 1'b1;
                end
            end
            default: begin
                st = bls_pkg::ST_INVALID;
            end
        endcase
    end

    assign o_mem_ctl.wr_en = accept && wr;
    assign o_mem_ctl.rd_en = accept && rd;
    assign o_mem_addr      = addr;
    assign o_res           = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_res.valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_res.valid <= 1'b1;
            end else if (i_take) begin
                r_res.valid <= 1'b0;
            end
        end
        if (accept) begin
            r_res.use_data <= rd;
            r_res.status   <= st;
            r_res.is_empty <= (n_count == '0);
            r_res.is_full  <= (ncnt_x >= cap_x) || (ncnt_x >= DEPTH_X);
        end
    end

endmodule

// ===== rtl/bounded_lifo_stack.sv =====
// Top level of the bounded LIFO stack: capacity register, controller, entry
// memory and output register. Depends on bls_pkg, bls_ctrl and bls_mem.
`timescale 1ns / 1ps

// A stack of DEPTH signed 32-bit words. Each input beat carries one operation
// (push, pop, peek at a depth from the top, read top, read bottom) and yields
// exactly one output beat with a value, a status and the empty and full flags
// as they stand after the operation. The block takes one beat per clock cycle
// when the output side keeps up; each beat passes through the synchronous read
// of the entry memory, held with the pending result, and then the output register.
// Every operation touches at most one memory entry, a read or a write, so
// consecutive beats need no forwarding. The capacity register caps the
// number of entries before the stack reports full and saturates at DEPTH;
// write it only while no beat is in flight. Entries hold no reset value, but
// only entries written by a push are ever read.
module bounded_lifo_stack #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bls_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bls_pkg::t_out o_out_data,
    input  logic          i_cfg_wr_en,
    input  logic [4:0]    i_cfg_wr_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [4:0]          r_capacity;
    logic                r_out_valid;
    bls_pkg::t_out       r_out;
    bls_pkg::t_mem_ctl   mem_ctl;
    logic [AW-1:0]       mem_addr;
    logic signed [31:0]  rd_data;
    bls_pkg::t_res_info  res;
    logic                take;

    // The pending result moves on when the output register is free or drains.
    assign take = res.valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= bls_pkg::CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_capacity <= i_cfg_wr_data;
        end
    end

    bls_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_capacity (r_capacity),
        .i_take     (take),
        .o_mem_ctl  (mem_ctl),
        .o_mem_addr (mem_addr),
        .o_res      (res)
    );

    bls_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_addr    (mem_addr),
        .i_wr_data (i_in_data.push_value),
        .o_rd_data (rd_data)
    );

    // Output register: errors and pushes report the error value instead of
    // memory data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (take) begin
            r_out.read_value <= res.use_data ? rd_data : bls_pkg::ERR_VALUE;
            r_out.status     <= res.status;
            r_out.is_empty   <= res.is_empty;
            r_out.is_full    <= res.is_full;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/bls_checker.sv =====
// Port-level checker for the bounded LIFO stack and its bind to the top level.
// Depends on bls_pkg and bounded_lifo_stack.
`timescale 1ns / 1ps

module bls_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input bls_pkg::t_out i_out_data
);

    // A result beat waiting for the consumer stays, with the same payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output beat dropped or changed while stalled");

    // Every error beat carries the error value.
    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status != bls_pkg::ST_OK
        |-> i_out_data.read_value == bls_pkg::ERR_VALUE)
        else $error("error beat without the error value");

    // An overflow leaves the stack full, an underflow leaves it empty.
    a_err_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (
            (i_out_data.status == bls_pkg::ST_OVERFLOW && !i_out_data.is_full) ||
            (i_out_data.status == bls_pkg::ST_UNDERFLOW && !i_out_data.is_empty))
        |-> 1'b0)
        else $error("status disagrees with the empty or full flag");

    // Reset clears any pending output beat.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind bounded_lifo_stack bls_checker u_bls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

// ===== tb/bounded_lifo_stack_test.sv =====
// Self-checking testbench for bounded_lifo_stack: a directed script followed by
// random traffic of every operation, checked against a stack predictor built in here.
// Depends on bls_pkg and the bounded_lifo_stack RTL.
`timescale 1ns / 1ps

module bounded_lifo_stack_test;

    localparam int DEPTH = 16;

    // Operation codes the block does not define; they must come back as an
    // invalid position with value -1 and leave the stack alone.
    localparam logic [2:0] OP_RSVD_LO = 3'd5;
    localparam logic [2:0] OP_RSVD_HI = 3'd7;

    // Cycles allowed after the last result before the block counts as idle.
    localparam int PIPE_SLACK      = 4;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PHASES          = 11;
    localparam int SEGMENTS        = 4;
    localparam int SEGMENT_BEATS   = 32;

    // Results that can be read straight off the operation and the stack size.
    localparam bls_pkg::t_out UNDER_EMPTY      =
        '{bls_pkg::ERR_VALUE, bls_pkg::ST_UNDERFLOW, 1'b1, 1'b0};
    localparam bls_pkg::t_out UNDER_EMPTY_FULL =
        '{bls_pkg::ERR_VALUE, bls_pkg::ST_UNDERFLOW, 1'b1, 1'b1};
    localparam bls_pkg::t_out BADPOS_EMPTY     =
        '{bls_pkg::ERR_VALUE, bls_pkg::ST_INVALID, 1'b1, 1'b0};
    localparam bls_pkg::t_out BADPOS           =
        '{bls_pkg::ERR_VALUE, bls_pkg::ST_INVALID, 1'b0, 1'b0};
    localparam bls_pkg::t_out PUSH_OK          =
        '{bls_pkg::ERR_VALUE, bls_pkg::ST_OK, 1'b0, 1'b0};
    localparam bls_pkg::t_out OVER_FULL        =
        '{bls_pkg::ERR_VALUE, bls_pkg::ST_OVERFLOW, 1'b0, 1'b1};
    localparam bls_pkg::t_out OVER_EMPTY_FULL  =
        '{bls_pkg::ERR_VALUE, bls_pkg::ST_OVERFLOW, 1'b1, 1'b1};
    localparam bls_pkg::t_out NO_WANT          = '0;
    localparam bls_pkg::t_in  NO_BEAT          = '0;

    // One row of the directed script. A row either writes the capacity
    // register or issues one beat. When typed is set the expected result is
    // the one written in the row; otherwise the predictor supplies it.
    typedef struct packed {
        logic          set_cap;
        logic [4:0]    cap;
        logic          typed;
        bls_pkg::t_in  beat;
        bls_pkg::t_out want;
    } t_script_row;

    localparam int SCRIPT_LEN = 28;
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        // Empty stack after reset: reads underflow, peeks and unknown codes
        // report an invalid position.
        '{1'b0, 5'd0, 1'b1, '{bls_pkg::OP_TOP,    32'sd0, 5'd0},  UNDER_EMPTY},
        '{1'b0, 5'd0, 1'b1, '{bls_pkg::OP_BOTTOM, 32'sd0, 5'd0},  UNDER_EMPTY},
        '{1'b0, 5'd0, 1'b1, '{bls_pkg::OP_POP,    32'sd0, 5'd0},  UNDER_EMPTY},
        '{1'b0, 5'd0, 1'b1, '{bls_pkg::OP_PEEK,   32'sd0, 5'd0},  BADPOS_EMPTY},
        '{1'b0, 5'd0, 1'b1, '{bls_pkg::OP_PEEK,   32'sd0, 5'd31}, BADPOS_EMPTY},
        '{1'b0, 5'd0, 1'b1, '{OP_RSVD_LO,         32'sd0, 5'd0},  BADPOS_EMPTY},
        '{1'b0, 5'd0, 1'b1, '{OP_RSVD_HI,         32'sd0, 5'd0},  BADPOS_EMPTY},
        // Extreme words, then reads of a three-entry stack: top, bottom, one past it.
        '{1'b0, 5'd0, 1'b1, '{bls_pkg::OP_PUSH, 32'sh7FFF_FFFF, 5'd31}, PUSH_OK},
        '{1'b0, 5'd0, 1'b1, '{bls_pkg::OP_PUSH, 32'sh8000_0000, 5'd0},  PUSH_OK},
        '{1'b0, 5'd0, 1'b1, '{bls_pkg::OP_PUSH, 32'shFFFF_FFFF, 5'd0},  PUSH_OK},
        '{1'b0, 5'd0, 1'b0, '{bls_pkg::OP_PEEK,   32'sd0, 5'd1}, NO_WANT},
        '{1'b0, 5'd0, 1'b0, '{bls_pkg::OP_PEEK,   32'sd0, 5'd3}, NO_WANT},
        '{1'b0, 5'd0, 1'b1, '{bls_pkg::OP_PEEK,   32'sd0, 5'd4}, BADPOS},
        '{1'b0, 5'd0, 1'b0, '{bls_pkg::OP_TOP,    32'sd0, 5'd0}, NO_WANT},
        '{1'b0, 5'd0, 1'b0, '{bls_pkg::OP_BOTTOM, 32'sd0, 5'd0}, NO_WANT},
        // Capacity equal to the count: full, the push overflows.
        '{1'b1, 5'd3, 1'b0, NO_BEAT, NO_WANT},
        '{1'b0, 5'd0, 1'b1, '{bls_pkg::OP_PUSH, 32'sd0, 5'd0}, OVER_FULL},
        // Capacity below the count: still full, but the held entries read.
        '{1'b1, 5'd1, 1'b0, NO_BEAT, NO_WANT},
        '{1'b0, 5'd0, 1'b0, '{bls_pkg::OP_POP,  32'sd0, 5'd0}, NO_WANT},
        '{1'b0, 5'd0, 1'b0, '{bls_pkg::OP_PEEK, 32'sd0, 5'd2}, NO_WANT},
        // Capacity zero: always full, even once empty.
        '{1'b1, 5'd0, 1'b0, NO_BEAT, NO_WANT},
        '{1'b0, 5'd0, 1'b0, '{bls_pkg::OP_POP,  32'sd0, 5'd0}, NO_WANT},
        '{1'b0, 5'd0, 1'b0, '{bls_pkg::OP_POP,  32'sd0, 5'd0}, NO_WANT},
        '{1'b0, 5'd0, 1'b1, '{bls_pkg::OP_PUSH, 32'sd7, 5'd0}, OVER_EMPTY_FULL},
        '{1'b0, 5'd0, 1'b1, '{bls_pkg::OP_POP,  32'sd0, 5'd0}, UNDER_EMPTY_FULL},
        // Capacity above DEPTH saturates, so one entry is far from full.
        '{1'b1, 5'd31, 1'b0, NO_BEAT, NO_WANT},
        '{1'b0, 5'd0, 1'b1, '{bls_pkg::OP_PUSH,   32'sh5A5A_5A5A, 5'd0}, PUSH_OK},
        '{1'b0, 5'd0, 1'b0, '{bls_pkg::OP_BOTTOM, 32'sd0,         5'd0}, NO_WANT}
    };

    // Capacity used by each random phase; the two marked 32 draw a random
    // setting at run time instead.
    localparam int PHASE_CAP [PHASES] = '{16, 31, 1, 0, 5, 16, 32, 2, 32, 20, 3};

    logic          clk         = 1'b0;
    logic          rst_n       = 1'b0;
    logic          in_valid    = 1'b0;
    logic          in_ready;
    bls_pkg::t_in  in_data     = '0;
    logic          out_valid;
    logic          out_ready   = 1'b0;
    bls_pkg::t_out out_data;
    logic          cfg_wr_en   = 1'b0;
    logic [4:0]    cfg_wr_data = '0;

    // Predictor state: the words held, how many, and the capacity register.
    logic signed [31:0] stk_words [DEPTH];
    int                 stk_count = 0;
    logic [4:0]         stk_cap   = bls_pkg::CAP_RESET;

    // Results the block still owes, oldest first.
    bls_pkg::t_out stack_replies [$];

    int   mismatches    = 0;
    int   idle_cycles   = 0;
    bit   tx_gaps_on    = 1'b1;
    bit   rx_gaps_on    = 1'b1;
    // Long hold-offs asked for by the stimulus; the receiver counts the ones
    // it has served.
    int   hold_off_reqs = 0;

    bounded_lifo_stack #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_in_data    (in_data),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_out_data   (out_data),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    always #10 clk = ~clk;

    // Applies one operation to the predicted stack and returns the result the
    // block must produce for it. The flags describe the stack afterwards.
    function automatic bls_pkg::t_out apply_stack_op(input bls_pkg::t_in b);
        bls_pkg::t_out r;
        int            lim;
        lim          = (stk_cap > DEPTH) ? DEPTH : int'(stk_cap);
        r.read_value = bls_pkg::ERR_VALUE;
        r.status     = bls_pkg::ST_OK;
        case (b.operation)
            bls_pkg::OP_PUSH: begin
                if (stk_count >= lim) begin
                    r.status = bls_pkg::ST_OVERFLOW;
                end else begin
                    stk_words[stk_count] = b.push_value;
                    stk_count++;
                end
            end
            bls_pkg::OP_POP: begin
                if (stk_count == 0) begin
                    r.status = bls_pkg::ST_UNDERFLOW;
                end else begin
                    stk_count--;
                    r.read_value = stk_words[stk_count];
                end
            end
            bls_pkg::OP_PEEK: begin
                if (b.depth_from_top == 0 || b.depth_from_top > stk_count)
                    r.status = bls_pkg::ST_INVALID;
                else
                    r.read_value = stk_words[stk_count - b.depth_from_top];
            end
            bls_pkg::OP_TOP: begin
                if (stk_count == 0)
                    r.status = bls_pkg::ST_UNDERFLOW;
                else
                    r.read_value = stk_words[stk_count - 1];
            end
            bls_pkg::OP_BOTTOM: begin
                if (stk_count == 0)
                    r.status = bls_pkg::ST_UNDERFLOW;
                else
                    r.read_value = stk_words[0];
            end
            default: begin
                r.status = bls_pkg::ST_INVALID;
            end
        endcase
        r.is_empty = (stk_count == 0);
        r.is_full  = (stk_count >= lim);
        return r;
    endfunction

    // Random operation. push_weight steers the stack toward full (high) or
    // toward empty (low). Peeks mostly land inside the stack; the rest, and
    // every ignored field, take any value the field can hold.
    function automatic bls_pkg::t_in random_beat(input int push_weight);
        bls_pkg::t_in b;
        int           r;
        int           s;
        r = $urandom_range(0, 99);
        s = $urandom_range(0, 9);
        case ($urandom_range(0, 7))
            0:       b.push_value = 32'sh7FFF_FFFF;
            1:       b.push_value = 32'sh8000_0000;
            default: b.push_value = $urandom;
        endcase
        b.depth_from_top = 5'($urandom_range(0, 31));
        if (r < 3)
            b.operation = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
        else if (r < 3 + push_weight)
            b.operation = bls_pkg::OP_PUSH;
        else if (s < 5)
            b.operation = bls_pkg::OP_POP;
        else if (s < 8)
            b.operation = bls_pkg::OP_PEEK;
        else if (s == 8)
            b.operation = bls_pkg::OP_TOP;
        else
            b.operation = bls_pkg::OP_BOTTOM;
        if (b.operation == bls_pkg::OP_PEEK && stk_count > 0 && $urandom_range(0, 3) != 0)
            b.depth_from_top = 5'($urandom_range(1, stk_count));
        return b;
    endfunction

    // Offers one beat, holding it until the block takes it, then records what
    // the block owes for it. A random gap may come first. After the accepting
    // edge valid is left high, so the next call either keeps it up with new
    // data or drops it for a gap: one assignment in that time step either way.
    task automatic issue_beat(input bls_pkg::t_in b, input bit typed,
                              input bls_pkg::t_out typed_want);
        bls_pkg::t_out pred;
        if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (!in_ready);
        pred = apply_stack_op(b);
        stack_replies.push_back(typed ? typed_want : pred);
    endtask

    // Stops offering and waits until every owed result has come back and the
    // pipeline has had time to empty.
    task automatic drain_stack();
        in_valid <= 1'b0;
        while (stack_replies.size() != 0) @(posedge clk);
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    // The capacity register may only change with no beat in flight.
    task automatic write_capacity(input logic [4:0] cap);
        drain_stack();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        stk_cap = cap;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%08h, got 0x%08h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Stimulus: reset, the directed script, then random phases. Each phase
    // sets a capacity and runs segments that fill, drain or churn the stack.
    initial begin : stimulus
        bls_pkg::t_in b;
        int           cap;
        int           mode;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SCRIPT[i]) begin
            if (SCRIPT[i].set_cap)
                write_capacity(SCRIPT[i].cap);
            else
                issue_beat(SCRIPT[i].beat, SCRIPT[i].typed, SCRIPT[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            cap = PHASE_CAP[ph];
            if (cap > 31)
                cap = $urandom_range(0, 31);
            write_capacity(5'(cap));
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                mode = $urandom_range(0, 2);
                if (ph == PHASES - 1) begin
                    // The closing phase runs with no gaps on either side.
                    tx_gaps_on = 1'b0;
                    rx_gaps_on = 1'b0;
                end else if (ph == 1 && seg == 0) begin
                    // Receiver stalls for a long stretch while pushes keep
                    // coming, so the block fills and backs up its input.
                    tx_gaps_on = 1'b0;
                    rx_gaps_on = 1'b0;
                    hold_off_reqs++;
                    mode       = 0;
                end else begin
                    tx_gaps_on = ($urandom_range(0, 3) != 0);
                    rx_gaps_on = ($urandom_range(0, 3) != 0);
                end
                for (int k = 0; k < SEGMENT_BEATS; k++) begin
                    b = random_beat(mode == 0 ? 65 : (mode == 1 ? 20 : 40));
                    issue_beat(b, 1'b0, NO_WANT);
                end
            end
        end

        drain_stack();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS bounded_lifo_stack");
        else
            $display("FAIL bounded_lifo_stack");
        $finish;
    end

    // Output side: ready drops in random bursts, or for one long hold-off
    // when the stimulus asks for it.
    initial begin : receiver
        int holds_done;
        holds_done = 0;
        forever begin
            @(posedge clk);
            if (hold_off_reqs != holds_done) begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else if (rx_gaps_on && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Every result beat is matched against the oldest owed result, field by
    // field. Signals are sampled at the edge, before any update it causes.
    always @(posedge clk) begin : result_check
        bls_pkg::t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (stack_replies.size() == 0) begin
                $display("%0t: result beat with nothing owed, got %h", $time, out_data);
                mismatches++;
            end else begin
                want = stack_replies.pop_front();
                check_field("read_value", want.read_value, out_data.read_value);
                check_field("status",     32'(want.status),   32'(out_data.status));
                check_field("is_empty",   32'(want.is_empty), 32'(out_data.is_empty));
                check_field("is_full",    32'(want.is_full),  32'(out_data.is_full));
            end
        end
    end

    // Ends the run if neither channel moves a beat for too long.
    always @(posedge clk) begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
            $display("FAIL bounded_lifo_stack");
            $finish;
        end
    end

endmodule
